/* design/u2da_pkg.sv */
// shared types, constants and decimal weight tables for the decimal ascii converter
`default_nettype none

package u2da_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned CHAR_W   = 6;
  localparam int unsigned WEIGHT_W = 34;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [COUNT_W-1:0] MAX_DIGITS = 4'd10;
  localparam logic [3:0]         MAX_DIGIT  = 4'd9;

  // one classified number waiting for conversion
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } item_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // power of ten for a digit position, 0 to 9
  function automatic logic [WEIGHT_W-1:0] pow10(input logic [3:0] pos);
    logic [WEIGHT_W-1:0] p;
    unique case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  // k times the power of ten at a position; k is a constant at every call
  function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [3:0] pos,
                                                       input logic [3:0] k);
    return pow10(pos) * WEIGHT_W'(k);
  endfunction

endpackage

`default_nettype wire

/* design/u2da_front.sv */
// front end: accepts numbers and counts their decimal digits
`default_nettype none

module u2da_front (
  input  wire logic                         push,
  input  wire logic                         full,
  input  wire logic [u2da_pkg::VALUE_W-1:0] value,
  output u2da_pkg::item_t                   wr_item,
  output logic                              wr_en
);
  import u2da_pkg::*;

  logic [COUNT_W-1:0] count;

  // digit count is one plus the number of powers of ten from 10 to 10^9 not above the value
  always_comb begin
    count = 4'd1;
    for (int i = 1; i < int'(MAX_DIGITS); i++) begin
      if ({2'b00, value} >= pow10(4'(i))) begin
        count = count + 4'd1;
      end
    end
  end

  // write the classified transaction into the queue
  assign wr_en         = push && !full;
  assign wr_item.value = value;
  assign wr_item.count = count;

endmodule

`default_nettype wire

/* design/u2da_queue.sv */
// short queue between front end and back end
`default_nettype none

module u2da_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire u2da_pkg::item_t wr_item,
  input  wire logic    rd_en,
  output u2da_pkg::head_t head,
  output logic         full
);
  import u2da_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_wr;
  logic              do_rd;

  assign full  = (fill == CNT_W'(DEPTH));
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && (fill != '0);

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];

endmodule

`default_nettype wire

/* design/u2da_back.sv */
// back end: emits digits most significant first, one per cycle while the output slot is free or being drained
`default_nettype none

module u2da_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire u2da_pkg::head_t             head,
  output logic                             rd_en,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [u2da_pkg::CHAR_W-1:0]      digit_char,
  output logic                             last,
  output logic [u2da_pkg::COUNT_W-1:0]     char_count
);
  import u2da_pkg::*;

  logic                 busy;
  logic [VALUE_W-1:0]   rem;
  logic [3:0]           pos;
  logic [COUNT_W-1:0]   cnt;
  logic                 out_valid;

  logic [VALUE_W-1:0]   src_rem;
  logic [3:0]           src_pos;
  logic [COUNT_W-1:0]   src_cnt;
  logic [3:0]           digit;
  logic [WEIGHT_W-1:0]  sub;
  logic [WEIGHT_W-1:0]  w;
  logic [VALUE_W-1:0]   rem_next;
  logic                 advance;
  logic                 act;

  // source is the running number, or the queue head when starting a new one
  always_comb begin
    src_rem = busy ? rem : head.item.value;
    src_pos = busy ? pos : head.item.count - 4'd1;
    src_cnt = busy ? cnt : head.item.count;
  end

  // pick the largest multiple of the position weight that fits
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    w     = '0;
    for (int k = 1; k <= int'(MAX_DIGIT); k++) begin
      w = digit_weight(src_pos, 4'(k));
      if ({2'b00, src_rem} >= w) begin
        digit = 4'(k);
        sub   = w;
      end
    end
    rem_next = src_rem - sub[VALUE_W-1:0];
  end

  // output slot takes a new digit when free or being drained
  assign advance = !out_valid || pop;
  assign act     = (busy || head.valid) && advance;
  assign rd_en   = act && !busy;
  assign empty   = !out_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (act) begin
        busy      <= (src_pos != 4'd0);
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (act) begin
      rem        <= rem_next;
      pos        <= src_pos - 4'd1;
      cnt        <= src_cnt;
      digit_char <= ASCII_ZERO + CHAR_W'(digit);
      last       <= (src_pos == 4'd0);
      char_count <= src_cnt;
    end
  end

endmodule

`default_nettype wire

/* design/unsigned_to_decimal_ascii_unit.sv */
// top level of the unsigned 32-bit to decimal ascii converter
//
// Input channel: a 32-bit unsigned value is taken when push is high and full
// is low. Result channel: while empty is low, digit_char, last and char_count
// show the oldest waiting digit; it is taken when pop is high.
// Each number yields 1 to 10 digit transactions, most significant first, no
// leading zeros; last marks the final digit and char_count carries the digit
// total on every digit of the run.
// The front end counts digits with parallel compares against powers of ten
// and writes the number into a short queue. The back end peels one digit per
// cycle while the output slot is free or being drained, by comparing against
// the nine multiples of the current power of ten. An accepted number is
// written into the queue; its digits are then registered into the output
// slot. The queue takes new numbers while the back end still emits an earlier
// one. If pop stays low the digit holds, the back end stops, the queue fills
// and full rises; nothing is lost. Reset clears the queue and the output slot.
`default_nettype none

module unsigned_to_decimal_ascii_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [u2da_pkg::VALUE_W-1:0] value,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [u2da_pkg::CHAR_W-1:0]       digit_char,
  output logic                              last,
  output logic [u2da_pkg::COUNT_W-1:0]      char_count
);
  import u2da_pkg::*;

  item_t wr_item;
  logic  wr_en;
  head_t head;
  logic  rd_en;

  u2da_front u_front (
    .push    (push),
    .full    (full),
    .value   (value),
    .wr_item (wr_item),
    .wr_en   (wr_en)
  );

  u2da_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (rd_en),
    .head    (head),
    .full    (full)
  );

  u2da_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .rd_en      (rd_en),
    .pop        (pop),
    .empty      (empty),
    .digit_char (digit_char),
    .last       (last),
    .char_count (char_count)
  );

`ifndef SYNTHESIS
  // shown digit is always an ascii decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
    else $error("digit_char out of ascii digit range");

  // digit total stays within one to ten
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (char_count != 4'd0) && (char_count <= MAX_DIGITS))
    else $error("char_count out of range");

  // after a non-final digit is taken the next digit of the run follows at once
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (!empty && $stable(char_count)))
    else $error("digit run broken or count changed mid-run");
`endif

endmodule

`default_nettype wire

/* test/unsigned_to_decimal_ascii_unit_tb.sv */
// testbench for the unsigned 32-bit to decimal ascii converter
`default_nettype none

module unsigned_to_decimal_ascii_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2da_pkg::*;

  localparam int unsigned DEC_BASE     = 10;
  localparam int unsigned RANDOM_ITEMS = 32;
  localparam int unsigned SETTLE_CYCLES = 20;

  // one expected digit transaction
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               lst;
    logic [COUNT_W-1:0] cnt;
  } digit_t;

  // expected digit stream and mismatch count
  class digit_scoreboard;
    digit_t pending_digits[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // expand an accepted number into its digits, most significant first
    function void note_value(input logic [VALUE_W-1:0] number);
      logic [3:0]         digits[10];
      logic [VALUE_W-1:0] rest;
      int                 n;
      digit_t             d;
      rest = number;
      n = 0;
      do begin
        digits[n] = 4'(rest % DEC_BASE);
        rest = rest / DEC_BASE;
        n++;
      end while (rest != 0);
      for (int k = 0; k < n; k++) begin
        d.ch  = CHAR_W'(ASCII_ZERO + CHAR_W'(digits[n-1-k]));
        d.lst = (k == n - 1);
        d.cnt = COUNT_W'(n);
        pending_digits.push_back(d);
      end
    endfunction

    // compare a popped digit with the oldest expectation
    function void check_digit(input logic [CHAR_W-1:0] ch, input logic lst,
                              input logic [COUNT_W-1:0] cnt);
      digit_t d;
      if (pending_digits.size() == 0) begin
        $error("unexpected digit transaction: digit_char %0d last %0d char_count %0d",
               ch, lst, cnt);
        errors++;
      end else begin
        d = pending_digits.pop_front();
        if (ch !== d.ch) begin
          $error("digit_char: expected %0d, got %0d", d.ch, ch);
          errors++;
        end
        if (lst !== d.lst) begin
          $error("last: expected %0d, got %0d", d.lst, lst);
          errors++;
        end
        if (cnt !== d.cnt) begin
          $error("char_count: expected %0d, got %0d", d.cnt, cnt);
          errors++;
        end
      end
    endfunction

    function int remaining();
      return pending_digits.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [VALUE_W-1:0] value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;
  logic [COUNT_W-1:0] char_count;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;

  digit_scoreboard sb = new();

  unsigned_to_decimal_ascii_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last       (last),
    .char_count (char_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // check every popped digit
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_digit(digit_char, last, char_count);
    end
  end

  // offer one number, idling first at random; push stays high afterwards
  task automatic send_value(input logic [VALUE_W-1:0] number);
    while ($urandom_range(99) < sender_idle_pct) begin
      push = 1'b0;
      value = $urandom;
      @(negedge clk);
    end
    push = 1'b1;
    value = number;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_value(number);
    @(negedge clk);
  endtask

  // hold the sender until every expected digit has come out
  task automatic drain();
    push = 1'b0;
    while (sb.remaining() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // number with a random digit count, sometimes a raw 32-bit pattern
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned       n;
    longint unsigned   p;
    longint unsigned   lo;
    longint unsigned   hi;
    if ($urandom_range(9) == 0) return $urandom;
    n = $urandom_range(10, 1);
    p = 1;
    repeat (n - 1) p = p * DEC_BASE;
    lo = (n == 1) ? 0 : p;
    hi = p * DEC_BASE - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  // stimulus and end of run
  initial begin
    logic [VALUE_W-1:0] directed_values[$];
    directed_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
                        32'd1000, 32'd9999, 32'd10000, 32'd99999, 32'd100000,
                        32'd999999, 32'd1000000, 32'd9999999, 32'd10000000,
                        32'd99999999, 32'd100000000, 32'd999999999,
                        32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                        32'h5555_5555, 32'hAAAA_AAAA};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender idles less than the receiver
    sender_idle_pct = 32;
    receiver_idle_pct = 59;
    foreach (directed_values[i]) send_value(directed_values[i]);
    drain();
    repeat (RANDOM_ITEMS) send_value(random_value());
    drain();

    // receiver idles less than the sender
    sender_idle_pct = 59;
    receiver_idle_pct = 32;
    repeat (RANDOM_ITEMS) send_value(random_value());
    drain();

    // no idling on either side
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (RANDOM_ITEMS) send_value(random_value());
    push = 1'b0;

    while (sb.remaining() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.remaining() == 0) begin
      $display("unsigned_to_decimal_ascii_unit_tb passed");
    end else begin
      $display("unsigned_to_decimal_ascii_unit_tb failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #2ms;
    $display("unsigned_to_decimal_ascii_unit_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
